FILE: rtl/vtpp_pkg.sv
// Shared types, constants and helpers for the VLAN tag push/pop unit.
package vtpp_pkg;

    // Frame byte position counter and header layout
    localparam int unsigned POS_W     = 5;
    localparam int unsigned MAC_IDX_W = 4;

    localparam logic [POS_W-1:0] MAC_LEN         = 5'd12;
    localparam logic [POS_W-1:0] POS_TYPE_HI     = 5'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO     = 5'd13;
    localparam logic [POS_W-1:0] POS_INNER_HI    = 5'd16;
    localparam logic [POS_W-1:0] POS_STRIP_BURST = 5'd17;
    localparam logic [POS_W-1:0] POS_SAT         = 5'd18;

    // Header burst item indexes
    localparam logic [POS_W-1:0] BIDX_STRIP_TYPE = 5'd12;
    localparam logic [POS_W-1:0] BIDX_STRIP_LAST = 5'd13;
    localparam logic [POS_W-1:0] BIDX_TPID_HI    = 5'd12;
    localparam logic [POS_W-1:0] BIDX_TPID_LO    = 5'd13;
    localparam logic [POS_W-1:0] BIDX_TCI_HI     = 5'd14;
    localparam logic [POS_W-1:0] BIDX_TCI_LO     = 5'd15;
    localparam logic [POS_W-1:0] BIDX_PUSH_TYPE  = 5'd16;
    localparam logic [POS_W-1:0] BIDX_PUSH_LAST  = 5'd17;

    // Tag protocol identifiers
    localparam logic [7:0] TPID_CTAG_HI = 8'h81;
    localparam logic [7:0] TPID_CTAG_LO = 8'h00;
    localparam logic [7:0] TPID_STAG_HI = 8'h88;
    localparam logic [7:0] TPID_STAG_LO = 8'hA8;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_TRUNK_PORT  = 2'd0;
    localparam logic [1:0] CFG_IDX_ACCESS_PORT = 2'd1;
    localparam logic [1:0] CFG_IDX_PUSH_TCI    = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_DROP    = 2'd1,
        VERDICT_ABORT   = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        PATH_WAIT    = 2'd0,
        PATH_TRUNK   = 2'd1,
        PATH_ACCESS  = 2'd2,
        PATH_UNKNOWN = 2'd3
    } path_t;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_SINGLE      = 3'd1,
        ACT_VERDICT     = 3'd2,
        ACT_BURST_STRIP = 3'd3,
        ACT_BURST_PUSH  = 3'd4
    } action_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] ingress_port;
        logic       frame_end;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [7:0] egress_port;
        verdict_t   verdict;
        logic       out_end;
    } result_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0]  trunk_port_id;
        logic [7:0]  access_port_id;
        logic [15:0] push_tag_control;
    } cfg_regs_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             load;
        logic             from_burst;
        logic [POS_W-1:0] burst_idx;
        logic             burst_push;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
    } dp_status_t;

    function automatic logic is_vlan_tpid(input logic [7:0] hi, input logic [7:0] lo);
        is_vlan_tpid = ((hi == TPID_CTAG_HI) && (lo == TPID_CTAG_LO))
                    || ((hi == TPID_STAG_HI) && (lo == TPID_STAG_LO));
    endfunction

endpackage

FILE: rtl/vtpp_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface vtpp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: rtl/vtpp_cfg_regs.sv
// Configuration register file for the VLAN tag push/pop unit.
module vtpp_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    vtpp_chan_if.sink           cfg,
    output vtpp_pkg::cfg_regs_t regs
);

    vtpp_pkg::cfg_regs_t regs_reg;
    vtpp_pkg::cfg_regs_t regs_next;

    // Always take a write transaction
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.payload.index)
                vtpp_pkg::CFG_IDX_TRUNK_PORT:  regs_next.trunk_port_id    = cfg.payload.data[7:0];
                vtpp_pkg::CFG_IDX_ACCESS_PORT: regs_next.access_port_id   = cfg.payload.data[7:0];
                vtpp_pkg::CFG_IDX_PUSH_TCI:    regs_next.push_tag_control = cfg.payload.data;
                default:                       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: rtl/vtpp_ctrl.sv
// Controller: input/output handshake and header burst sequencing.
module vtpp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  vtpp_pkg::dp_status_t status,
    output vtpp_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [vtpp_pkg::POS_W-1:0] burst_cnt_reg;
    logic [vtpp_pkg::POS_W-1:0] burst_cnt_next;
    logic                       burst_push_reg;
    logic                       burst_push_next;
    logic [vtpp_pkg::POS_W-1:0] burst_last;
    logic                       slot_free;
    logic                       accept;

    // Output slot is free when empty or being drained this cycle
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign burst_last = burst_push_reg ? vtpp_pkg::BIDX_PUSH_LAST : vtpp_pkg::BIDX_STRIP_LAST;

    // Sequence pass-through, verdict and header burst results
    always_comb
    begin
        state_next      = state_reg;
        burst_cnt_next  = burst_cnt_reg;
        burst_push_next = burst_push_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd.accept      = accept;
        cmd.load        = 1'b0;
        cmd.from_burst  = 1'b0;
        cmd.burst_idx   = burst_cnt_reg;
        cmd.burst_push  = burst_push_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.action)
                        vtpp_pkg::ACT_SINGLE,
                        vtpp_pkg::ACT_VERDICT:
                        begin
                            cmd.load       = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        vtpp_pkg::ACT_BURST_STRIP:
                        begin
                            state_next      = ST_BURST;
                            burst_cnt_next  = '0;
                            burst_push_next = 1'b0;
                        end
                        vtpp_pkg::ACT_BURST_PUSH:
                        begin
                            state_next      = ST_BURST;
                            burst_cnt_next  = '0;
                            burst_push_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                if (slot_free)
                begin
                    cmd.load       = 1'b1;
                    cmd.from_burst = 1'b1;
                    out_valid_next = 1'b1;
                    if (burst_cnt_reg == burst_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        burst_cnt_next = burst_cnt_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            burst_cnt_reg  <= '0;
            burst_push_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            burst_cnt_reg  <= burst_cnt_next;
            burst_push_reg <= burst_push_next;
        end
    end

endmodule

FILE: rtl/vtpp_datapath.sv
// Datapath: frame parsing state, held MAC bytes and the output register.
module vtpp_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vtpp_pkg::frame_item_t  item,
    input  vtpp_pkg::cfg_regs_t    regs,
    input  vtpp_pkg::dp_cmd_t      cmd,
    output vtpp_pkg::dp_status_t   status,
    output vtpp_pkg::result_item_t result
);

    logic [vtpp_pkg::POS_W-1:0] pos_reg;
    logic [vtpp_pkg::POS_W-1:0] pos_next;
    vtpp_pkg::path_t            path_reg;
    vtpp_pkg::path_t            path_next;
    vtpp_pkg::verdict_t         fate_reg;
    vtpp_pkg::verdict_t         fate_next;
    logic [7:0]                 th_reg;
    logic [7:0]                 th_next;
    logic [7:0]                 mac_mem [12];
    logic [7:0]                 hold_byte_reg;
    logic                       hold_last_reg;
    vtpp_pkg::result_item_t     result_reg;
    vtpp_pkg::result_item_t     result_next;

    vtpp_pkg::path_t            path_eff;
    vtpp_pkg::verdict_t         fate_ent;
    vtpp_pkg::verdict_t         fate_chk;
    vtpp_pkg::verdict_t         fate_new;
    vtpp_pkg::action_t          action;
    logic                       mac_we;
    logic [7:0]                 b;

    assign b             = item.frame_byte;
    assign status.action = action;
    assign result        = result_reg;

    // Classify the current byte against the frame state
    always_comb
    begin
        path_eff = path_reg;
        fate_ent = fate_reg;
        if (path_reg == vtpp_pkg::PATH_WAIT)
        begin
            if (item.ingress_port == regs.trunk_port_id)
            begin
                path_eff = vtpp_pkg::PATH_TRUNK;
            end
            else if (item.ingress_port == regs.access_port_id)
            begin
                path_eff = vtpp_pkg::PATH_ACCESS;
            end
            else
            begin
                path_eff = vtpp_pkg::PATH_UNKNOWN;
                fate_ent = vtpp_pkg::VERDICT_ABORT;
            end
        end

        // Frame ends before its header is complete
        fate_chk = fate_ent;
        if (item.frame_end && (fate_ent == vtpp_pkg::VERDICT_FORWARD))
        begin
            if ((path_eff == vtpp_pkg::PATH_TRUNK) && (pos_reg < vtpp_pkg::POS_STRIP_BURST))
            begin
                fate_chk = vtpp_pkg::VERDICT_DROP;
            end
            else if ((path_eff == vtpp_pkg::PATH_ACCESS) && (pos_reg < vtpp_pkg::POS_TYPE_LO))
            begin
                fate_chk = vtpp_pkg::VERDICT_ABORT;
            end
        end

        fate_new = fate_chk;
        th_next  = th_reg;
        mac_we   = 1'b0;
        action   = vtpp_pkg::ACT_NONE;
        if (fate_chk == vtpp_pkg::VERDICT_FORWARD)
        begin
            if (pos_reg < vtpp_pkg::MAC_LEN)
            begin
                mac_we = 1'b1;
            end
            else if (path_eff == vtpp_pkg::PATH_TRUNK)
            begin
                if ((pos_reg == vtpp_pkg::POS_TYPE_HI) || (pos_reg == vtpp_pkg::POS_INNER_HI))
                begin
                    th_next = b;
                end
                else if (pos_reg == vtpp_pkg::POS_TYPE_LO)
                begin
                    if (!vtpp_pkg::is_vlan_tpid(th_reg, b))
                    begin
                        fate_new = vtpp_pkg::VERDICT_DROP;
                    end
                end
                else if (pos_reg == vtpp_pkg::POS_STRIP_BURST)
                begin
                    action = vtpp_pkg::ACT_BURST_STRIP;
                end
                else if (pos_reg >= vtpp_pkg::POS_SAT)
                begin
                    action = vtpp_pkg::ACT_SINGLE;
                end
            end
            else
            begin
                if (pos_reg == vtpp_pkg::POS_TYPE_HI)
                begin
                    th_next = b;
                end
                else if (pos_reg == vtpp_pkg::POS_TYPE_LO)
                begin
                    if (vtpp_pkg::is_vlan_tpid(th_reg, b))
                    begin
                        fate_new = vtpp_pkg::VERDICT_DROP;
                    end
                    else
                    begin
                        action = vtpp_pkg::ACT_BURST_PUSH;
                    end
                end
                else
                begin
                    action = vtpp_pkg::ACT_SINGLE;
                end
            end
        end

        // Dropped or aborted frame reports once at its last byte
        if (item.frame_end && (fate_new != vtpp_pkg::VERDICT_FORWARD))
        begin
            action = vtpp_pkg::ACT_VERDICT;
        end
    end

    // Advance the frame state, clear it at the last byte
    always_comb
    begin
        pos_next  = pos_reg;
        path_next = path_reg;
        fate_next = fate_reg;
        if (cmd.accept)
        begin
            if (item.frame_end)
            begin
                pos_next  = '0;
                path_next = vtpp_pkg::PATH_WAIT;
                fate_next = vtpp_pkg::VERDICT_FORWARD;
            end
            else
            begin
                pos_next  = (pos_reg < vtpp_pkg::POS_SAT) ? (pos_reg + 5'd1) : pos_reg;
                path_next = path_eff;
                fate_next = fate_new;
            end
        end
    end

    // Build the next result: burst item, pass-through byte or verdict
    always_comb
    begin
        result_next             = '0;
        result_next.has_byte    = 1'b1;
        result_next.verdict     = vtpp_pkg::VERDICT_FORWARD;
        if (cmd.from_burst)
        begin
            result_next.egress_port = cmd.burst_push ? regs.trunk_port_id : regs.access_port_id;
            if (cmd.burst_idx < vtpp_pkg::MAC_LEN)
            begin
                result_next.out_byte = mac_mem[cmd.burst_idx[vtpp_pkg::MAC_IDX_W-1:0]];
            end
            else if (!cmd.burst_push)
            begin
                if (cmd.burst_idx == vtpp_pkg::BIDX_STRIP_TYPE)
                begin
                    result_next.out_byte = th_reg;
                end
                else
                begin
                    result_next.out_byte = hold_byte_reg;
                    result_next.out_end  = hold_last_reg;
                end
            end
            else if (cmd.burst_idx == vtpp_pkg::BIDX_TPID_HI)
            begin
                result_next.out_byte = vtpp_pkg::TPID_CTAG_HI;
            end
            else if (cmd.burst_idx == vtpp_pkg::BIDX_TPID_LO)
            begin
                result_next.out_byte = vtpp_pkg::TPID_CTAG_LO;
            end
            else if (cmd.burst_idx == vtpp_pkg::BIDX_TCI_HI)
            begin
                result_next.out_byte = regs.push_tag_control[15:8];
            end
            else if (cmd.burst_idx == vtpp_pkg::BIDX_TCI_LO)
            begin
                result_next.out_byte = regs.push_tag_control[7:0];
            end
            else if (cmd.burst_idx == vtpp_pkg::BIDX_PUSH_TYPE)
            begin
                result_next.out_byte = th_reg;
            end
            else
            begin
                result_next.out_byte = hold_byte_reg;
                result_next.out_end  = hold_last_reg;
            end
        end
        else if (action == vtpp_pkg::ACT_VERDICT)
        begin
            result_next.has_byte = 1'b0;
            result_next.verdict  = fate_new;
            result_next.out_end  = 1'b1;
        end
        else
        begin
            result_next.out_byte    = b;
            result_next.egress_port = (path_eff == vtpp_pkg::PATH_TRUNK)
                                      ? regs.access_port_id : regs.trunk_port_id;
            result_next.out_end     = item.frame_end;
        end
    end

    // Frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            path_reg <= vtpp_pkg::PATH_WAIT;
            fate_reg <= vtpp_pkg::VERDICT_FORWARD;
            th_reg   <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            path_reg <= path_next;
            fate_reg <= fate_next;
            if (cmd.accept)
            begin
                th_reg <= th_next;
            end
        end
    end

    // Hold MAC bytes, the header-closing byte and the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && mac_we)
        begin
            mac_mem[pos_reg[vtpp_pkg::MAC_IDX_W-1:0]] <= b;
        end
        if (cmd.accept)
        begin
            hold_byte_reg <= b;
            hold_last_reg <= item.frame_end;
        end
        if (cmd.load)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/vlan_tag_push_pop_unit.sv
// VLAN tag push/pop unit: 802.1Q tag strip on trunk frames, tag insert on access frames.
//
// Channels: frames (frame_byte, ingress_port, frame_end) in, results out, and a
// configuration write channel (index 0 trunk port, 1 access port, 2 pushed TCI) that
// always takes its transaction. Configuration must be written between frames; the unit
// does not enforce this. Each accepted byte yields at most one result, except the byte
// that closes the header: on a trunk frame byte 17 releases 14 results (MAC bytes,
// inner type), on an access frame byte 13 releases 18 results (MAC bytes, pushed tag,
// type). Results leave through a single output register: a pass-through or verdict
// result shows up in the cycle after its byte is accepted, burst results once the
// controller's ST_BURST state loads them. Pass-through bytes flow at one per cycle
// while the output is not stalled; the header-closing byte holds off the input while
// the burst drains from the held MAC bytes one result per cycle unless the output stalls.
// MAC bytes and the first type bytes give no result until the header is complete.
// Dropped or aborted frames give one verdict-only result at their last byte.
// Reset returns the parser to awaiting a first byte, clears the configuration to
// zero and empties the output register. While results.ready is low the output
// register holds its transaction and the input stops taking bytes once it is full.
module vlan_tag_push_pop_unit (
    input  logic        clk,
    input  logic        rst_n,
    vtpp_chan_if.sink   frames,
    vtpp_chan_if.source results,
    vtpp_chan_if.sink   cfg
);

    vtpp_pkg::cfg_regs_t    regs;
    vtpp_pkg::dp_cmd_t      cmd;
    vtpp_pkg::dp_status_t   status;
    vtpp_pkg::result_item_t result;
    logic                   in_ready;
    logic                   out_valid;

    vtpp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    vtpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frames.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vtpp_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (frames.payload),
        .regs   (regs),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // Drive the channel ports
    assign frames.ready    = in_ready;
    assign results.valid   = out_valid;
    assign results.payload = result;

    // A burst load never coincides with taking a new byte
    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.from_burst) |-> !cmd.accept)
        else $error("input transaction taken during header burst");

    // The output register is only reloaded when its transaction leaves
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && results.valid) |-> results.ready)
        else $error("output register overwritten while stalled");

    // Starting a header burst holds off the input on the next cycle
    a_burst_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && ((status.action == vtpp_pkg::ACT_BURST_STRIP)
                        || (status.action == vtpp_pkg::ACT_BURST_PUSH))) |=> !frames.ready)
        else $error("input ready right after header burst start");

endmodule

FILE: bench/tb_vlan_tag_push_pop_unit.sv
// Self-checking bench for the VLAN tag push/pop unit: directed table, then random frames.
module tb_vlan_tag_push_pop_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD      = 1;
    localparam int DRAIN_CYCLES     = 24;
    localparam int ITEM_TARGET      = 500;
    localparam int FRAMES_PER_PHASE = 6;
    localparam int TIMEOUT_NS       = 5_000_000;

    // Index outside the register map; the unit must ignore it
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        vtpp_pkg::cfg_write_t   cfg;
        vtpp_pkg::frame_item_t  item;
        logic                   chk;
        vtpp_pkg::result_item_t want;
    } dir_row_t;

    typedef enum int {
        FR_TRUNK_OK,
        FR_TRUNK_SHORT,
        FR_TRUNK_BAD_TPID,
        FR_ACCESS_OK,
        FR_ACCESS_TAGGED,
        FR_ACCESS_SHORT,
        FR_STRAY
    } frame_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Free-running clock
    always #HALF_PERIOD clk = ~clk;

    vtpp_chan_if #(.payload_t(vtpp_pkg::frame_item_t))  frames_if ();
    vtpp_chan_if #(.payload_t(vtpp_pkg::result_item_t)) results_if ();
    vtpp_chan_if #(.payload_t(vtpp_pkg::cfg_write_t))   cfg_if ();

    vlan_tag_push_pop_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Shadow of the frame parser and of the registers
    logic [7:0]                 pp_mac [12];
    logic [vtpp_pkg::POS_W-1:0] pp_pos;
    vtpp_pkg::path_t            pp_path;
    logic [7:0]                 pp_type_hi;
    vtpp_pkg::verdict_t         pp_fate;
    logic [7:0]                 sh_trunk;
    logic [7:0]                 sh_access;
    logic [15:0]                sh_tci;

    vtpp_pkg::result_item_t egress_due [$];
    int                     fail_count = 0;
    int                     items_sent = 0;
    bit                     src_steady = 1'b0;

    function automatic logic vlan_ethertype(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] tpid;
        tpid = {hi, lo};
        return (tpid == {vtpp_pkg::TPID_CTAG_HI, vtpp_pkg::TPID_CTAG_LO})
            || (tpid == {vtpp_pkg::TPID_STAG_HI, vtpp_pkg::TPID_STAG_LO});
    endfunction

    function automatic vtpp_pkg::result_item_t data_out(input logic [7:0] b,
                                                        input logic [7:0] eg,
                                                        input logic last);
        vtpp_pkg::result_item_t r;
        r.out_byte    = b;
        r.has_byte    = 1'b1;
        r.egress_port = eg;
        r.verdict     = vtpp_pkg::VERDICT_FORWARD;
        r.out_end     = last;
        return r;
    endfunction

    function automatic vtpp_pkg::result_item_t verdict_only(input vtpp_pkg::verdict_t v);
        vtpp_pkg::result_item_t r;
        r.out_byte    = 8'h00;
        r.has_byte    = 1'b0;
        r.egress_port = 8'h00;
        r.verdict     = v;
        r.out_end     = 1'b1;
        return r;
    endfunction

    // Advance the shadow parser by one byte and return the results it releases
    function automatic void push_pop_byte(input vtpp_pkg::frame_item_t it,
                                          output vtpp_pkg::result_item_t res[$]);
        logic [vtpp_pkg::POS_W-1:0] p;
        logic [7:0]                 b;
        logic                       last;
        res  = {};
        b    = it.frame_byte;
        last = it.frame_end;

        // Classify the frame on its first byte; trunk wins on equal ids
        if (pp_path == vtpp_pkg::PATH_WAIT)
        begin
            if (it.ingress_port == sh_trunk)
                pp_path = vtpp_pkg::PATH_TRUNK;
            else if (it.ingress_port == sh_access)
                pp_path = vtpp_pkg::PATH_ACCESS;
            else
            begin
                pp_path = vtpp_pkg::PATH_UNKNOWN;
                pp_fate = vtpp_pkg::VERDICT_ABORT;
            end
        end
        p = pp_pos;

        // Frame ends before its header is complete
        if (last && pp_fate == vtpp_pkg::VERDICT_FORWARD)
        begin
            if (pp_path == vtpp_pkg::PATH_TRUNK && p < vtpp_pkg::POS_STRIP_BURST)
                pp_fate = vtpp_pkg::VERDICT_DROP;
            else if (pp_path == vtpp_pkg::PATH_ACCESS && p < vtpp_pkg::POS_TYPE_LO)
                pp_fate = vtpp_pkg::VERDICT_ABORT;
        end

        if (pp_fate == vtpp_pkg::VERDICT_FORWARD)
        begin
            if (p < vtpp_pkg::MAC_LEN)
            begin
                pp_mac[p[vtpp_pkg::MAC_IDX_W-1:0]] = b;
            end
            else if (pp_path == vtpp_pkg::PATH_TRUNK)
            begin
                // Strip: check the outer tag, release MACs plus inner type
                if (p == vtpp_pkg::POS_TYPE_HI || p == vtpp_pkg::POS_INNER_HI)
                    pp_type_hi = b;
                else if (p == vtpp_pkg::POS_TYPE_LO)
                begin
                    if (!vlan_ethertype(pp_type_hi, b))
                        pp_fate = vtpp_pkg::VERDICT_DROP;
                end
                else if (p == vtpp_pkg::POS_STRIP_BURST)
                begin
                    foreach (pp_mac[i])
                        res.push_back(data_out(pp_mac[i], sh_access, 1'b0));
                    res.push_back(data_out(pp_type_hi, sh_access, 1'b0));
                    res.push_back(data_out(b, sh_access, last));
                end
                else if (p >= vtpp_pkg::POS_SAT)
                    res.push_back(data_out(b, sh_access, last));
            end
            else
            begin
                // Push: reject tagged frames, insert a C-tag after the MACs
                if (p == vtpp_pkg::POS_TYPE_HI)
                    pp_type_hi = b;
                else if (p == vtpp_pkg::POS_TYPE_LO)
                begin
                    if (vlan_ethertype(pp_type_hi, b))
                        pp_fate = vtpp_pkg::VERDICT_DROP;
                    else
                    begin
                        foreach (pp_mac[i])
                            res.push_back(data_out(pp_mac[i], sh_trunk, 1'b0));
                        res.push_back(data_out(vtpp_pkg::TPID_CTAG_HI, sh_trunk, 1'b0));
                        res.push_back(data_out(vtpp_pkg::TPID_CTAG_LO, sh_trunk, 1'b0));
                        res.push_back(data_out(sh_tci[15:8], sh_trunk, 1'b0));
                        res.push_back(data_out(sh_tci[7:0], sh_trunk, 1'b0));
                        res.push_back(data_out(pp_type_hi, sh_trunk, 1'b0));
                        res.push_back(data_out(b, sh_trunk, last));
                    end
                end
                else
                    res.push_back(data_out(b, sh_trunk, last));
            end
        end

        if (pp_pos < vtpp_pkg::POS_SAT)
            pp_pos = pp_pos + 1'b1;

        // Close the frame
        if (last)
        begin
            if (pp_fate != vtpp_pkg::VERDICT_FORWARD)
                res.push_back(verdict_only(pp_fate));
            pp_pos     = '0;
            pp_path    = vtpp_pkg::PATH_WAIT;
            pp_type_hi = 8'h00;
            pp_fate    = vtpp_pkg::VERDICT_FORWARD;
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic dir_row_t item_row(input logic [7:0] b, input logic [7:0] port,
                                          input logic last);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.frame_byte   = b;
        r.item.ingress_port = port;
        r.item.frame_end    = last;
        return r;
    endfunction

    function automatic dir_row_t verdict_row(input logic [7:0] b, input logic [7:0] port,
                                             input vtpp_pkg::verdict_t v);
        dir_row_t r;
        r = item_row(b, port, 1'b1);
        r.chk  = 1'b1;
        r.want = verdict_only(v);
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
        dir_row_t r;
        r = '0;
        r.kind      = ROW_CFG;
        r.cfg.index = idx;
        r.cfg.data  = data;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_result(input vtpp_pkg::result_item_t got);
        vtpp_pkg::result_item_t want;
        if (egress_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte %h has %b port %h verdict %0d end %b",
                                      got.out_byte, got.has_byte, got.egress_port,
                                      got.verdict, got.out_end));
        end
        else
        begin
            want = egress_due.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.egress_port !== want.egress_port || got.verdict !== want.verdict ||
                got.out_end !== want.out_end)
                report_mismatch($sformatf(
                    "got/exp byte %h/%h has %b/%b port %h/%h verdict %0d/%0d end %b/%b",
                    got.out_byte, want.out_byte, got.has_byte, want.has_byte,
                    got.egress_port, want.egress_port, got.verdict, want.verdict,
                    got.out_end, want.out_end));
        end
    endtask

    // Offer one frame byte, hold it until taken, then record what it should release
    task automatic send_item(input vtpp_pkg::frame_item_t it, input logic chk,
                             input vtpp_pkg::result_item_t want);
        int                     gap;
        vtpp_pkg::result_item_t outs [$];
        gap = src_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            frames_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames_if.valid   <= 1'b1;
        frames_if.payload <= it;
        @(posedge clk);
        while (!frames_if.ready)
            @(posedge clk);
        items_sent++;
        push_pop_byte(it, outs);
        if (chk)
            egress_due.push_back(want);
        else
            foreach (outs[i])
                egress_due.push_back(outs[i]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        vtpp_pkg::cfg_write_t w;
        w.index = idx;
        w.data  = data;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            vtpp_pkg::CFG_IDX_TRUNK_PORT:  sh_trunk  = data[7:0];
            vtpp_pkg::CFG_IDX_ACCESS_PORT: sh_access = data[7:0];
            vtpp_pkg::CFG_IDX_PUSH_TCI:    sh_tci    = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stop offering bytes and wait until every expected result has drained
    task automatic settle();
        frames_if.valid <= 1'b0;
        while (egress_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Build and send one random frame, mostly well-formed
    task automatic send_frame();
        frame_kind_t           kind;
        logic [7:0]            body [$];
        logic [7:0]            port;
        int                    len;
        int                    extra;
        int                    r;
        bit                    want_tag;
        bit                    want_plain;
        vtpp_pkg::frame_item_t it;

        r = $urandom_range(0, 99);
        if (r < 32)
            kind = FR_TRUNK_OK;
        else if (r < 64)
            kind = FR_ACCESS_OK;
        else if (r < 72)
            kind = FR_TRUNK_SHORT;
        else if (r < 80)
            kind = FR_TRUNK_BAD_TPID;
        else if (r < 88)
            kind = FR_ACCESS_TAGGED;
        else if (r < 94)
            kind = FR_ACCESS_SHORT;
        else
            kind = FR_STRAY;

        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        case (kind)
            FR_TRUNK_OK:       len = 18 + extra;
            FR_TRUNK_SHORT:    len = $urandom_range(1, 17);
            FR_ACCESS_SHORT:   len = $urandom_range(1, 13);
            FR_STRAY:          len = $urandom_range(1, 20);
            default:           len = 14 + extra;
        endcase

        for (int i = 0; i < len; i++)
            body.push_back(8'($urandom_range(0, 255)));

        want_tag   = (kind == FR_TRUNK_OK) || (kind == FR_ACCESS_TAGGED) ||
                     (kind == FR_TRUNK_SHORT && len >= 14 && $urandom_range(0, 1) == 1);
        want_plain = (kind == FR_TRUNK_BAD_TPID) || (kind == FR_ACCESS_OK);

        // Place a valid tag, or a type that is not one (often a near miss)
        if (want_tag)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                body[12] = vtpp_pkg::TPID_CTAG_HI;
                body[13] = vtpp_pkg::TPID_CTAG_LO;
            end
            else
            begin
                body[12] = vtpp_pkg::TPID_STAG_HI;
                body[13] = vtpp_pkg::TPID_STAG_LO;
            end
        end
        if (want_plain)
        begin
            if ($urandom_range(0, 2) == 0)
                body[12] = ($urandom_range(0, 1) == 1) ? vtpp_pkg::TPID_CTAG_HI
                                                       : vtpp_pkg::TPID_STAG_HI;
            while (vlan_ethertype(body[12], body[13]))
                body[13] = 8'($urandom_range(0, 255));
        end

        case (kind)
            FR_TRUNK_OK, FR_TRUNK_SHORT, FR_TRUNK_BAD_TPID: port = sh_trunk;
            FR_ACCESS_OK, FR_ACCESS_TAGGED, FR_ACCESS_SHORT: port = sh_access;
            default:
            begin
                port = 8'($urandom_range(0, 255));
                while (port == sh_trunk || port == sh_access)
                    port = 8'($urandom_range(0, 255));
            end
        endcase

        src_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            it.frame_byte   = body[i];
            it.ingress_port = (i == 0) ? port : 8'($urandom_range(0, 255));
            it.frame_end    = (i == len - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result side: check each transaction, stall at random
    initial
    begin : result_sink
        int hold_left;
        int steady_left;
        hold_left   = 0;
        steady_left = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_if.valid === 1'b1 && results_if.ready === 1'b1)
                check_result(results_if.payload);
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
                if (steady_left > 0)
                    steady_left--;
                else if ($urandom_range(0, 99) < 3)
                    steady_left = $urandom_range(30, 150);
                else
                    hold_left = idle_len();
            end
        end
    end

    // Frame and configuration side
    initial
    begin : stimulus
        dir_row_t    dir_rows [$];
        int          random_start;
        int          phase;
        logic [7:0]  t_id;
        logic [7:0]  a_id;
        logic [15:0] tci;

        frames_if.valid   <= 1'b0;
        frames_if.payload <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.payload    <= '0;

        // Shadow state after reset
        foreach (pp_mac[i])
            pp_mac[i] = 8'h00;
        pp_pos     = '0;
        pp_path    = vtpp_pkg::PATH_WAIT;
        pp_type_hi = 8'h00;
        pp_fate    = vtpp_pkg::VERDICT_FORWARD;
        sh_trunk   = 8'h00;
        sh_access  = 8'h00;
        sh_tci     = 16'h0000;

        dir_rows = {
            // Reset values: both ids zero, so port zero takes the trunk path
            verdict_row(8'hFF, 8'h01, vtpp_pkg::VERDICT_ABORT),
            verdict_row(8'h00, 8'h00, vtpp_pkg::VERDICT_DROP),
            cfg_row(vtpp_pkg::CFG_IDX_TRUNK_PORT, 16'h0000),
            cfg_row(vtpp_pkg::CFG_IDX_ACCESS_PORT, 16'h00FF),
            cfg_row(vtpp_pkg::CFG_IDX_PUSH_TCI, 16'hFFFF),
            // Short access frames
            verdict_row(8'hAA, 8'hFF, vtpp_pkg::VERDICT_ABORT),
            item_row(8'h55, 8'hFF, 1'b0),
            verdict_row(8'hFF, 8'h00, vtpp_pkg::VERDICT_ABORT),
            // Access frame that already carries an S-tag
            item_row(8'hFF, 8'hFF, 1'b0), item_row(8'h00, 8'h3C, 1'b0),
            item_row(8'hFF, 8'h00, 1'b0), item_row(8'h00, 8'hFF, 1'b0),
            item_row(8'h12, 8'hC3, 1'b0), item_row(8'h34, 8'h5A, 1'b0),
            item_row(8'h56, 8'hA5, 1'b0), item_row(8'h78, 8'h0F, 1'b0),
            item_row(8'h9A, 8'hF0, 1'b0), item_row(8'hBC, 8'h81, 1'b0),
            item_row(8'hDE, 8'h7E, 1'b0), item_row(8'hF0, 8'h18, 1'b0),
            item_row(vtpp_pkg::TPID_STAG_HI, 8'hE7, 1'b0),
            verdict_row(vtpp_pkg::TPID_STAG_LO, 8'h66, vtpp_pkg::VERDICT_DROP)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_rows[i].cfg.index, dir_rows[i].cfg.data);
            end
            else
                send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].want);
        end

        // Random phases, each under its own register setting
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < ITEM_TARGET)
        begin
            settle();
            case (phase)
                0:
                begin
                    t_id = 8'h00;
                    a_id = 8'hFF;
                    tci  = 16'h0000;
                end
                1:
                begin
                    t_id = 8'hFF;
                    a_id = 8'h00;
                    tci  = 16'hFFFF;
                end
                2:
                begin
                    t_id = 8'($urandom_range(0, 255));
                    a_id = t_id;
                    tci  = 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    t_id = 8'($urandom_range(0, 255));
                    a_id = 8'($urandom_range(0, 255));
                    tci  = 16'($urandom_range(0, 65535));
                end
            endcase
            if (phase % 2 == 1)
                write_reg(CFG_IDX_UNUSED, 16'($urandom_range(0, 65535)));
            write_reg(vtpp_pkg::CFG_IDX_TRUNK_PORT, {8'($urandom_range(0, 255)), t_id});
            write_reg(vtpp_pkg::CFG_IDX_ACCESS_PORT, {8'($urandom_range(0, 255)), a_id});
            write_reg(vtpp_pkg::CFG_IDX_PUSH_TCI, tci);
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
                send_frame();
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("tb_vlan_tag_push_pop_unit passed");
        else
            $display("tb_vlan_tag_push_pop_unit failed");
        $finish;
    end

    // Hard stop for a hung run
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_vlan_tag_push_pop_unit failed");
        $finish;
    end

endmodule
